@@ rtl/xrae_pkg.sv @@
`timescale 1ns / 1ps
package xrae_pkg;

	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned SLOT_W   = 3;

	localparam logic [15:0] SIGN_WORD = 16'h8000;
	localparam logic [15:0] HI_BYTE   = 16'hFF00;
	localparam logic [15:0] LO_BYTE   = 16'h00FF;
	localparam logic [15:0] SIGN_BYTE = 16'h0080;
	localparam int unsigned FLAG_Z    = 0;
	localparam int unsigned FLAG_S    = 1;

	typedef enum logic [1:0] {
		MODE_MOV = 2'd0,
		MODE_ADD = 2'd1,
		MODE_SUB = 2'd2,
		MODE_CMP = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  dst_reg;
		logic        src_is_reg;
		logic [3:0]  src_reg;
		logic [15:0] immediate;
	} cmd_t;

	typedef struct packed {
		logic [15:0] old_value;
		logic [15:0] new_value;
		logic        zero_flag;
		logic        sign_flag;
	} res_t;

	// write-back port into the register file
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       data;
	} wb_t;

	// codes 0-3 ax..dx, 4-11 byte halves of ax..dx, 12-15 sp,bp,si,di
	function automatic logic [SLOT_W-1:0] reg_slot(input logic [3:0] code);
		logic [SLOT_W-1:0] s;
		if (code[3:2] == 2'b11) begin
			s = {1'b1, code[1:0]};
		end else begin
			s = {1'b0, code[1:0]};
		end
		return s;
	endfunction

	function automatic logic reg_is_byte(input logic [3:0] code);
		return (code[3:2] == 2'b01) || (code[3:2] == 2'b10);
	endfunction

	function automatic logic reg_is_high(input logic [3:0] code);
		return code[3:2] == 2'b01;
	endfunction

	// value of a register code as seen by an instruction, bytes zero-extended
	function automatic logic [15:0] reg_view(input logic [15:0] word, input logic [3:0] code);
		logic [15:0] v;
		if (!reg_is_byte(code)) begin
			v = word;
		end else if (reg_is_high(code)) begin
			v = {8'h00, word[15:8]};
		end else begin
			v = word & LO_BYTE;
		end
		return v;
	endfunction

endpackage

@@ rtl/xrae_regfile.sv @@
`timescale 1ns / 1ps
module xrae_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [xrae_pkg::SLOT_W-1:0] rd_slot_a,
	input  logic [xrae_pkg::SLOT_W-1:0] rd_slot_b,
	input  xrae_pkg::wb_t              wb,
	output logic [15:0]                rd_data_a,
	output logic [15:0]                rd_data_b
);
	import xrae_pkg::*;

	logic [15:0] regs_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{default: 16'h0000};
		end else if (wb.en) begin
			regs_q[wb.slot] <= wb.data;
		end
	end

	// registered read; forward a write landing on the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wb.en && (wb.slot == rd_slot_a)) begin
				rd_data_a <= wb.data;
			end else begin
				rd_data_a <= regs_q[rd_slot_a];
			end
			if (wb.en && (wb.slot == rd_slot_b)) begin
				rd_data_b <= wb.data;
			end else begin
				rd_data_b <= regs_q[rd_slot_b];
			end
		end
	end

endmodule

@@ rtl/xrae_exec.sv @@
`timescale 1ns / 1ps
module xrae_exec (
	input  logic               go,
	input  xrae_pkg::cmd_t     cmd,
	input  logic [15:0]        dst_word,
	input  logic [15:0]        src_word,
	input  logic [1:0]         flags,
	output xrae_pkg::res_t     res,
	output xrae_pkg::wb_t      wb,
	output logic               flag_we
);
	import xrae_pkg::*;

	logic        byte_op;
	logic [15:0] mask;
	logic [15:0] sign_bit;
	logic [15:0] a;
	logic [15:0] b;
	logic [15:0] sval;
	logic [15:0] r;
	logic [15:0] after;
	logic        z;
	logic        s;
	logic        write;

	always_comb begin
		byte_op  = reg_is_byte(cmd.dst_reg);
		mask     = byte_op ? LO_BYTE : 16'hFFFF;
		sign_bit = byte_op ? SIGN_BYTE : SIGN_WORD;
		a        = reg_view(dst_word, cmd.dst_reg);
		sval     = cmd.src_is_reg ? reg_view(src_word, cmd.src_reg) : cmd.immediate;
		b        = sval & mask;
		r        = '0;
		after    = a;
		write    = 1'b0;
		flag_we  = 1'b0;
		unique case (mode_t'(cmd.mode))
			MODE_MOV: begin
				after = b;
				write = 1'b1;
			end
			MODE_ADD: begin
				r       = (a + b) & mask;
				after   = r;
				write   = 1'b1;
				flag_we = 1'b1;
			end
			MODE_SUB: begin
				r       = (a - b) & mask;
				after   = r;
				write   = 1'b1;
				flag_we = 1'b1;
			end
			MODE_CMP: begin
				r       = (a - b) & mask;
				flag_we = 1'b1;
			end
			default: begin
				r = '0;
			end
		endcase
		z = (r == 16'h0000);
		s = (r & sign_bit) != 16'h0000;

		res.old_value = a;
		res.new_value = after;
		res.zero_flag = flag_we ? z : flags[FLAG_Z];
		res.sign_flag = flag_we ? s : flags[FLAG_S];

		// merge the lane back into the full word
		wb.en   = go && write;
		wb.slot = reg_slot(cmd.dst_reg);
		if (!byte_op) begin
			wb.data = after;
		end else if (reg_is_high(cmd.dst_reg)) begin
			wb.data = (dst_word & LO_BYTE) | {after[7:0], 8'h00};
		end else begin
			wb.data = (dst_word & HI_BYTE) | (after & LO_BYTE);
		end
	end

endmodule

@@ rtl/x86_register_alu_exec.sv @@
`timescale 1ns / 1ps
// Executes one mov, add, sub or cmp per transaction against eight 16-bit
// registers (ax..dx also addressable as byte halves). The register file is
// read into the operand register as the command is taken, and the
// add/subtract, flag update and write-back happen when the command advances
// out of the operand register, which also loads the result register. A new
// command is accepted every cycle; a write-back is forwarded into the operand
// read on the same edge, so dependent commands may follow back to back.
// Throughput drops only while the result register is held by a low
// res_ready. Registers and flags reset to zero.
module x86_register_alu_exec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  xrae_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output xrae_pkg::res_t   res
);
	import xrae_pkg::*;

	cmd_t        cmd_s1;
	logic        valid_s1;
	logic [15:0] dst_word_s1;
	logic [15:0] src_word_s1;
	logic [1:0]  flags_q;
	res_t        res_s2;
	logic        valid_s2;

	res_t        exec_res;
	wb_t         wb;
	logic        flag_we;
	logic        advance;
	logic        take;

	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign take      = cmd_valid && cmd_ready;

	xrae_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (take),
		.rd_slot_a (reg_slot(cmd.dst_reg)),
		.rd_slot_b (reg_slot(cmd.src_reg)),
		.wb        (wb),
		.rd_data_a (dst_word_s1),
		.rd_data_b (src_word_s1)
	);

	xrae_exec u_exec (
		.go       (advance),
		.cmd      (cmd_s1),
		.dst_word (dst_word_s1),
		.src_word (src_word_s1),
		.flags    (flags_q),
		.res      (exec_res),
		.wb       (wb),
		.flag_we  (flag_we)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
			if (advance && flag_we) begin
				flags_q[FLAG_Z] <= exec_res.zero_flag;
				flags_q[FLAG_S] <= exec_res.sign_flag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
		if (advance) begin
			res_s2 <= exec_res;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	a_cmp_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (cmd_s1.mode == MODE_CMP) |-> !wb.en)
		else $error("cmp wrote the register file");

	a_cmp_same: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1.mode == MODE_CMP) |=> res.old_value == res.new_value)
		else $error("cmp result changed the destination");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.zero_flag && res.sign_flag))
		else $error("zero and sign both set");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("command stalled with empty result register");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import xrae_pkg::*;

	localparam logic [3:0] REG_AX = 4'd0;
	localparam logic [3:0] REG_BX = 4'd1;
	localparam logic [3:0] REG_CX = 4'd2;
	localparam logic [3:0] REG_DX = 4'd3;
	localparam logic [3:0] REG_AH = 4'd4;
	localparam logic [3:0] REG_BH = 4'd5;
	localparam logic [3:0] REG_CH = 4'd6;
	localparam logic [3:0] REG_DH = 4'd7;
	localparam logic [3:0] REG_AL = 4'd8;
	localparam logic [3:0] REG_BL = 4'd9;
	localparam logic [3:0] REG_CL = 4'd10;
	localparam logic [3:0] REG_DL = 4'd11;
	localparam logic [3:0] REG_SP = 4'd12;
	localparam logic [3:0] REG_BP = 4'd13;
	localparam logic [3:0] REG_SI = 4'd14;
	localparam logic [3:0] REG_DI = 4'd15;

	localparam int RANDOM_OPS   = 900;
	localparam int IDLE_PERCENT = 31;
	localparam int STALL_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 20;

	class reg_file_scoreboard;
		logic [15:0] regs [8];
		logic zf;
		logic sf;
		res_t pending_results [$];
		int errors;
		int compared;
		int ops_taken;
		int mode_count [4];

		function new();
			regs = '{default: 16'h0000};
			zf = 1'b0;
			sf = 1'b0;
			errors = 0;
			compared = 0;
			ops_taken = 0;
			mode_count = '{default: 0};
		endfunction

		function logic [15:0] read_reg(logic [3:0] code);
			logic [15:0] w;
			w = (code[3:2] == 2'b11) ? regs[{1'b1, code[1:0]}] : regs[{1'b0, code[1:0]}];
			case (code[3:2])
				2'b01: return {8'h00, w[15:8]};
				2'b10: return {8'h00, w[7:0]};
				default: return w;
			endcase
		endfunction

		function void write_reg(logic [3:0] code, logic [15:0] v);
			case (code[3:2])
				2'b00: regs[{1'b0, code[1:0]}] = v;
				2'b01: regs[{1'b0, code[1:0]}][15:8] = v[7:0];
				2'b10: regs[{1'b0, code[1:0]}][7:0] = v[7:0];
				default: regs[{1'b1, code[1:0]}] = v;
			endcase
		endfunction

		// Work out the result of one accepted instruction and queue it.
		function void execute_instruction(cmd_t c);
			mode_t op;
			logic byte_lane;
			logic [15:0] lane_mask;
			logic [15:0] top_bit;
			logic [15:0] dst_val;
			logic [15:0] src_val;
			logic [15:0] outcome;
			logic [15:0] after;
			res_t r;
			op = mode_t'(c.mode);
			byte_lane = (c.dst_reg[3:2] == 2'b01) || (c.dst_reg[3:2] == 2'b10);
			lane_mask = byte_lane ? 16'h00FF : 16'hFFFF;
			top_bit = byte_lane ? 16'h0080 : 16'h8000;
			dst_val = read_reg(c.dst_reg);
			src_val = (c.src_is_reg ? read_reg(c.src_reg) : c.immediate) & lane_mask;
			after = dst_val;
			case (op)
				MODE_MOV: begin
					after = src_val;
					write_reg(c.dst_reg, after);
				end
				MODE_ADD, MODE_SUB, MODE_CMP: begin
					outcome = ((op == MODE_ADD) ? dst_val + src_val : dst_val - src_val) & lane_mask;
					zf = (outcome == 16'h0000);
					sf = |(outcome & top_bit);
					if (op != MODE_CMP) begin
						after = outcome;
						write_reg(c.dst_reg, after);
					end
				end
			endcase
			r.old_value = dst_val;
			r.new_value = after;
			r.zero_flag = zf;
			r.sign_flag = sf;
			pending_results.push_back(r);
			ops_taken++;
			mode_count[c.mode]++;
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result expected none actual %h", $time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("old_value", want.old_value, got.old_value);
			compare_field("new_value", want.new_value, got.new_value);
			compare_field("zero_flag", {15'd0, want.zero_flag}, {15'd0, got.zero_flag});
			compare_field("sign_flag", {15'd0, want.sign_flag}, {15'd0, got.sign_flag});
			compared++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	logic steady = 1'b0;
	int quiet_cycles = 0;
	reg_file_scoreboard sb = new();

	x86_register_alu_exec u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Sample both channels on the pre-edge values.
	always @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			sb.execute_instruction(cmd);
		end
		if (res_valid && res_ready) begin
			sb.check_result(res);
		end
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic issue(input mode_t op, input logic [3:0] dst, input logic from_reg,
			input logic [3:0] src, input logic [15:0] imm);
		cmd_t c;
		c.mode = op;
		c.dst_reg = dst;
		c.src_is_reg = from_reg;
		c.src_reg = src;
		c.immediate = imm;
		// drop valid only while idling, so it is never lowered and raised in one step
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_immediate();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return {8'h00, 8'($urandom_range(126, 129))};
			5: return 16'($urandom_range(0, 2));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [3:0] dst;
		logic [3:0] src;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		issue(MODE_MOV, REG_AX, 1'b0, REG_AX, 16'hFFFF);
		issue(MODE_MOV, REG_SP, 1'b0, REG_DI, 16'h8000);
		issue(MODE_MOV, REG_DI, 1'b0, REG_SI, 16'h0001);
		// byte destination takes only the low byte of the immediate
		issue(MODE_MOV, REG_BH, 1'b0, REG_BX, 16'h12AB);
		issue(MODE_MOV, REG_CL, 1'b1, REG_DI, 16'hA5A5);
		issue(MODE_ADD, REG_AX, 1'b0, REG_CX, 16'h0001);
		issue(MODE_ADD, REG_BH, 1'b0, REG_AX, 16'hFF55);
		issue(MODE_SUB, REG_CX, 1'b0, REG_AX, 16'h0001);
		issue(MODE_SUB, REG_DL, 1'b0, REG_AX, 16'h0001);
		// mov after a sign result reports the held flags
		issue(MODE_MOV, REG_DH, 1'b0, REG_AX, 16'hFF00);
		issue(MODE_CMP, REG_SP, 1'b0, REG_AX, 16'h0001);
		issue(MODE_CMP, REG_SP, 1'b1, REG_SP, 16'h0000);
		issue(MODE_MOV, REG_SI, 1'b1, REG_DL, 16'h0000);
		issue(MODE_ADD, REG_DX, 1'b1, REG_SP, 16'h0000);
		issue(MODE_ADD, REG_AH, 1'b1, REG_DL, 16'h0000);
		issue(MODE_SUB, REG_BP, 1'b0, REG_AX, 16'hFFFF);
		issue(MODE_CMP, REG_AL, 1'b0, REG_AX, 16'h0080);
		issue(MODE_ADD, REG_DI, 1'b0, REG_AX, 16'h7FFF);
		issue(MODE_CMP, REG_BL, 1'b1, REG_BH, 16'h0000);
		issue(MODE_MOV, REG_CH, 1'b1, REG_CL, 16'h0000);
		issue(MODE_SUB, REG_SI, 1'b1, REG_SI, 16'h0000);
		issue(MODE_MOV, REG_BX, 1'b1, REG_CH, 16'h0000);
		issue(MODE_ADD, REG_BL, 1'b1, REG_AX, 16'h0000);
		issue(MODE_CMP, REG_DI, 1'b1, REG_BP, 16'h0000);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			steady <= (n >= 300) && (n < 550);
			dst = 4'($urandom_range(0, 15));
			src = ($urandom_range(0, 3) == 0) ? dst : 4'($urandom_range(0, 15));
			issue(mode_t'($urandom_range(0, 3)), dst, 1'($urandom_range(0, 1)), src,
				pick_immediate());
		end
		cmd_valid <= 1'b0;

		while (sb.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("executed %0d instructions: %0d mov, %0d add, %0d sub, %0d cmp",
			sb.ops_taken, sb.mode_count[MODE_MOV], sb.mode_count[MODE_ADD],
			sb.mode_count[MODE_SUB], sb.mode_count[MODE_CMP]);
		$display("compared %0d results, %0d field errors", sb.compared, sb.errors);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ x86_register_alu_exec.f @@
rtl/xrae_pkg.sv
rtl/xrae_regfile.sv
rtl/xrae_exec.sv
rtl/x86_register_alu_exec.sv
test/tb_top.sv
